// ===== sv/mbd_pkg.sv =====
// ----------------------------------------------------------------------------
// mbd_pkg: shared types and constants of the multipart body deframer
// Phase codes, result kinds, error codes, character constants and the
// packed payload types of the input and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

package mbd_pkg;

  // Parse phases
  typedef enum logic [3:0] {
    PH_PRE_MATCH   = 4'd0,
    PH_PRE_SKIP    = 4'd1,
    PH_PRE_SKIP_CR = 4'd2,
    PH_AFTER_B     = 4'd3,
    PH_DASH2       = 4'd4,
    PH_SPACES      = 4'd5,
    PH_B_LF        = 4'd6,
    PH_LINE_START  = 4'd7,
    PH_BLANK_LF    = 4'd8,
    PH_NAME        = 4'd9,
    PH_NAME_SP     = 4'd10,
    PH_VALUE       = 4'd11,
    PH_VALUE_LF    = 4'd12,
    PH_BODY        = 4'd13,
    PH_DONE        = 4'd14,
    PH_ERROR       = 4'd15
  } phase_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_NAME     = 3'd0,
    KIND_VALUE    = 3'd1,
    KIND_LINE_END = 3'd2,
    KIND_HDR_END  = 3'd3,
    KIND_BODY     = 3'd4,
    KIND_PART_END = 3'd5,
    KIND_DONE     = 3'd6,
    KIND_ERROR    = 3'd7
  } kind_t;

  // Error codes
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_PREMATURE = 3'd1,
    ERR_NO_CRLF   = 3'd2,
    ERR_BLANK     = 3'd3,
    ERR_NO_SPACE  = 3'd4,
    ERR_NO_LF     = 3'd5
  } err_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_BLEN  = 2'd0;
  localparam logic [1:0] CFG_BLOW  = 2'd1;
  localparam logic [1:0] CFG_BHIGH = 2'd2;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  // Characters
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DASH  = 8'd45;

  // Result queue depth
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;
  localparam int OQ_CNT_W = 3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_body;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [2:0] error_code;
    logic       last_of_run;
  } res_item_t;

endpackage

`default_nettype wire

// ===== sv/multipart_body_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// multipart_body_deframer_unit: streaming multipart body parser
// Latency: results of a byte enter the output queue at the edge that takes
// the byte and are offered from the next cycle on.
// Throughput: one byte per cycle unless in_stall is high; the 4-entry result
// queue drains one result per cycle while out_stall is low.
// Reset (synchronous, rst_n low): parser back to preamble search, queue
// empty, boundary length 1 and boundary bytes zero.
// ----------------------------------------------------------------------------
`default_nettype none

module multipart_body_deframer_unit #(
  parameter int MAX_BOUNDARY = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration write port
  input  wire logic                             cfg_wr_en,
  input  wire logic [mbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mbd_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input byte channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire mbd_pkg::in_item_t                in_data,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output mbd_pkg::res_item_t                    out_data
);

  localparam int D      = MAX_BOUNDARY + 4;       // delay window depth
  localparam int AUG_N  = MAX_BOUNDARY + 2;       // "--" plus boundary
  localparam int MC_W   = $clog2(AUG_N + 1);
  localparam int AIX_W  = $clog2(AUG_N);
  localparam int FILL_W = $clog2(D + 1);
  localparam int WIX_W  = $clog2(D);
  localparam int LEN_W  = $clog2(MAX_BOUNDARY + 1);

  // Configuration registers
  logic [4:0]  blen_r;
  logic [63:0] blow_r;
  logic [63:0] bhigh_r;

  // Parse state
  mbd_pkg::phase_t   phase_r, phase_nxt;
  logic [MC_W-1:0]   mc_r, mc_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0]        win_r [D];
  logic              win_load;

  // Result queue
  mbd_pkg::res_item_t           oq_r [mbd_pkg::OQ_DEPTH];
  logic [mbd_pkg::OQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [mbd_pkg::OQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [mbd_pkg::OQ_CNT_W-1:0] cnt_r, cnt_nxt;

  logic       accept, pop;
  logic [7:0] b;
  logic       eob;

  assign b      = in_data.in_byte;
  assign eob    = in_data.end_of_body;
  assign accept = in_valid && !in_stall;
  assign pop    = out_valid && !out_stall;

  // Effective lengths
  logic [LEN_W-1:0]  eff_len;
  logic [MC_W-1:0]   aug_len;
  logic [FILL_W-1:0] m_len, off;

  always_comb begin
    if (blen_r == 5'd0) begin
      eff_len = LEN_W'(1);
    end else if (int'(blen_r) > MAX_BOUNDARY) begin
      eff_len = LEN_W'(MAX_BOUNDARY);
    end else begin
      eff_len = LEN_W'(blen_r);
    end
  end

  assign aug_len = MC_W'(eff_len) + MC_W'(2);
  assign m_len   = FILL_W'(eff_len) + FILL_W'(4);
  assign off     = FILL_W'(D) - m_len;

  // Delimiter bytes: aug is "--" plus boundary, delim is CR LF plus aug
  logic [127:0] bnd;
  logic [7:0]   aug   [AUG_N];
  logic [7:0]   delim [D];

  assign bnd = {bhigh_r, blow_r};

  for (genvar gi = 0; gi < AUG_N; gi++) begin : g_aug
    if (gi < 2) begin : g_dash
      assign aug[gi] = mbd_pkg::CH_DASH;
    end else if (gi < 18) begin : g_bnd
      assign aug[gi] = bnd[8*(gi-2) +: 8];
    end else begin : g_zero
      assign aug[gi] = 8'd0;
    end
  end

  for (genvar gd = 0; gd < D; gd++) begin : g_delim
    if (gd == 0) begin : g_cr
      assign delim[gd] = mbd_pkg::CH_CR;
    end else if (gd == 1) begin : g_lf
      assign delim[gd] = mbd_pkg::CH_LF;
    end else begin : g_a
      assign delim[gd] = aug[gd-2];
    end
  end

  // Window after shifting in the new byte; newest byte sits at the top
  logic [7:0]        w_sh [D];
  logic [FILL_W-1:0] fill_t, fill_n;
  logic [D-1:0]      pos_ok;
  logic              win_match;
  logic [FILL_W-1:0] rel [D];

  always_comb begin
    for (int j = 0; j < D - 1; j++) begin
      w_sh[j] = win_r[j+1];
    end
    w_sh[D-1] = b;
  end

  assign fill_t = (fill_r > m_len - FILL_W'(1)) ? m_len - FILL_W'(1) : fill_r;
  assign fill_n = fill_t + FILL_W'(1);

  // Compare the newest m bytes of the window against CR LF "--" boundary
  always_comb begin
    for (int j = 0; j < D; j++) begin
      rel[j]    = FILL_W'(j) - off;
      pos_ok[j] = (FILL_W'(j) < off) || (w_sh[j] == delim[rel[j][WIX_W-1:0]]);
    end
  end

  assign win_match = &pos_ok;

  // Preamble match helpers
  logic [MC_W-1:0] mc_inc;
  logic            pre_hit, prev_cr;

  assign mc_inc  = mc_r + MC_W'(1);
  assign pre_hit = (mc_r < MC_W'(AUG_N)) && (b == aug[mc_r[AIX_W-1:0]]);
  assign prev_cr = (mc_r != '0) && (aug[mc_inc[AIX_W-1:0] - AIX_W'(2)] == mbd_pkg::CH_CR);

  // Next state and results
  logic       r0_vld, r1_vld;
  logic [2:0] r0_kind;
  logic [7:0] r0_byte;
  logic [2:0] r0_code;

  always_comb begin
    phase_nxt = phase_r;
    mc_nxt    = mc_r;
    fill_nxt  = fill_r;
    win_load  = 1'b0;
    r0_vld    = 1'b0;
    r0_kind   = mbd_pkg::KIND_NAME;
    r0_byte   = 8'd0;
    r0_code   = mbd_pkg::ERR_NONE;
    r1_vld    = 1'b0;

    unique case (phase_r)
      mbd_pkg::PH_PRE_MATCH: begin
        if (pre_hit) begin
          if (mc_inc >= aug_len) begin
            mc_nxt    = '0;
            phase_nxt = mbd_pkg::PH_AFTER_B;
          end else begin
            mc_nxt = mc_inc;
          end
        end else begin
          mc_nxt = '0;
          if (prev_cr && b == mbd_pkg::CH_LF) begin
            phase_nxt = mbd_pkg::PH_PRE_MATCH;
          end else if (b == mbd_pkg::CH_CR) begin
            phase_nxt = mbd_pkg::PH_PRE_SKIP_CR;
          end else begin
            phase_nxt = mbd_pkg::PH_PRE_SKIP;
          end
        end
      end
      mbd_pkg::PH_PRE_SKIP, mbd_pkg::PH_PRE_SKIP_CR: begin
        if (phase_r == mbd_pkg::PH_PRE_SKIP_CR && b == mbd_pkg::CH_LF) begin
          phase_nxt = mbd_pkg::PH_PRE_MATCH;
          mc_nxt    = '0;
        end else if (b == mbd_pkg::CH_CR) begin
          phase_nxt = mbd_pkg::PH_PRE_SKIP_CR;
        end else begin
          phase_nxt = mbd_pkg::PH_PRE_SKIP;
        end
      end
      mbd_pkg::PH_AFTER_B: begin
        if (!eob) begin
          if (b == mbd_pkg::CH_DASH) begin
            phase_nxt = mbd_pkg::PH_DASH2;
          end else if (b == mbd_pkg::CH_SPACE) begin
            phase_nxt = mbd_pkg::PH_SPACES;
          end else if (b == mbd_pkg::CH_CR) begin
            phase_nxt = mbd_pkg::PH_B_LF;
          end else begin
            r0_vld    = 1'b1;
            r0_kind   = mbd_pkg::KIND_ERROR;
            r0_code   = mbd_pkg::ERR_NO_CRLF;
            phase_nxt = mbd_pkg::PH_ERROR;
          end
        end
      end
      mbd_pkg::PH_DASH2: begin
        r0_vld = 1'b1;
        if (b == mbd_pkg::CH_DASH) begin
          r0_kind   = mbd_pkg::KIND_DONE;
          phase_nxt = mbd_pkg::PH_DONE;
        end else begin
          r0_kind   = mbd_pkg::KIND_ERROR;
          r0_code   = mbd_pkg::ERR_NO_CRLF;
          phase_nxt = mbd_pkg::PH_ERROR;
        end
      end
      mbd_pkg::PH_SPACES: begin
        if (b == mbd_pkg::CH_CR) begin
          phase_nxt = mbd_pkg::PH_B_LF;
        end else if (b != mbd_pkg::CH_SPACE) begin
          r0_vld    = 1'b1;
          r0_kind   = mbd_pkg::KIND_ERROR;
          r0_code   = mbd_pkg::ERR_NO_CRLF;
          phase_nxt = mbd_pkg::PH_ERROR;
        end
      end
      mbd_pkg::PH_B_LF: begin
        if (b == mbd_pkg::CH_LF) begin
          phase_nxt = mbd_pkg::PH_LINE_START;
        end else begin
          r0_vld    = 1'b1;
          r0_kind   = mbd_pkg::KIND_ERROR;
          r0_code   = mbd_pkg::ERR_NO_CRLF;
          phase_nxt = mbd_pkg::PH_ERROR;
        end
      end
      mbd_pkg::PH_LINE_START: begin
        if (b == mbd_pkg::CH_CR) begin
          phase_nxt = mbd_pkg::PH_BLANK_LF;
        end else if (b == mbd_pkg::CH_COLON) begin
          phase_nxt = mbd_pkg::PH_NAME_SP;
        end else begin
          r0_vld    = 1'b1;
          r0_kind   = mbd_pkg::KIND_NAME;
          r0_byte   = b;
          phase_nxt = mbd_pkg::PH_NAME;
        end
      end
      mbd_pkg::PH_BLANK_LF: begin
        r0_vld = 1'b1;
        if (b == mbd_pkg::CH_LF) begin
          r0_kind   = mbd_pkg::KIND_HDR_END;
          fill_nxt  = '0;
          phase_nxt = mbd_pkg::PH_BODY;
        end else begin
          r0_kind   = mbd_pkg::KIND_ERROR;
          r0_code   = mbd_pkg::ERR_BLANK;
          phase_nxt = mbd_pkg::PH_ERROR;
        end
      end
      mbd_pkg::PH_NAME: begin
        if (b == mbd_pkg::CH_COLON) begin
          phase_nxt = mbd_pkg::PH_NAME_SP;
        end else begin
          r0_vld  = 1'b1;
          r0_kind = mbd_pkg::KIND_NAME;
          r0_byte = b;
        end
      end
      mbd_pkg::PH_NAME_SP: begin
        if (b == mbd_pkg::CH_SPACE) begin
          phase_nxt = mbd_pkg::PH_VALUE;
        end else begin
          r0_vld    = 1'b1;
          r0_kind   = mbd_pkg::KIND_ERROR;
          r0_code   = mbd_pkg::ERR_NO_SPACE;
          phase_nxt = mbd_pkg::PH_ERROR;
        end
      end
      mbd_pkg::PH_VALUE: begin
        if (b == mbd_pkg::CH_CR) begin
          phase_nxt = mbd_pkg::PH_VALUE_LF;
        end else begin
          r0_vld  = 1'b1;
          r0_kind = mbd_pkg::KIND_VALUE;
          r0_byte = b;
        end
      end
      mbd_pkg::PH_VALUE_LF: begin
        r0_vld = 1'b1;
        if (b == mbd_pkg::CH_LF) begin
          r0_kind   = mbd_pkg::KIND_LINE_END;
          phase_nxt = mbd_pkg::PH_LINE_START;
        end else begin
          r0_kind   = mbd_pkg::KIND_ERROR;
          r0_code   = mbd_pkg::ERR_NO_LF;
          phase_nxt = mbd_pkg::PH_ERROR;
        end
      end
      mbd_pkg::PH_BODY: begin
        win_load = 1'b1;
        if (fill_n == m_len) begin
          r0_vld = 1'b1;
          if (win_match) begin
            r0_kind   = mbd_pkg::KIND_PART_END;
            fill_nxt  = '0;
            phase_nxt = mbd_pkg::PH_AFTER_B;
          end else begin
            r0_kind  = mbd_pkg::KIND_BODY;
            r0_byte  = w_sh[off[WIX_W-1:0]];
            fill_nxt = m_len - FILL_W'(1);
          end
        end else begin
          fill_nxt = fill_n;
        end
      end
      mbd_pkg::PH_DONE, mbd_pkg::PH_ERROR: begin
        // ignore bytes until end of body
      end
    endcase

    // End of body: flag an unfinished body, then restart the parse
    if (eob) begin
      if (phase_nxt != mbd_pkg::PH_DONE && phase_nxt != mbd_pkg::PH_ERROR) begin
        r1_vld = 1'b1;
      end
      phase_nxt = mbd_pkg::PH_PRE_MATCH;
      mc_nxt    = '0;
      fill_nxt  = '0;
    end
  end

  // Assemble queue entries
  mbd_pkg::res_item_t e0, e1, r0_item, r1_item;
  logic [1:0]         push_cnt;

  always_comb begin
    r0_item.kind        = r0_kind;
    r0_item.out_byte    = r0_byte;
    r0_item.error_code  = r0_code;
    r0_item.last_of_run = !r1_vld;
    r1_item.kind        = mbd_pkg::KIND_ERROR;
    r1_item.out_byte    = 8'd0;
    r1_item.error_code  = mbd_pkg::ERR_PREMATURE;
    r1_item.last_of_run = 1'b1;
    e0       = r0_vld ? r0_item : r1_item;
    e1       = r1_item;
    push_cnt = {1'b0, r0_vld} + {1'b0, r1_vld};
  end

  // Queue pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (accept) begin
      wr_ptr_nxt = wr_ptr_r + mbd_pkg::OQ_PTR_W'(push_cnt);
      cnt_nxt    = cnt_r + mbd_pkg::OQ_CNT_W'(push_cnt);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + mbd_pkg::OQ_PTR_W'(1);
      cnt_nxt    = cnt_nxt - mbd_pkg::OQ_CNT_W'(1);
    end
  end

  // Stall input while the queue cannot take two more results
  assign in_stall  = cnt_r > mbd_pkg::OQ_CNT_W'(mbd_pkg::OQ_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_data  = oq_r[rd_ptr_r];

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blen_r   <= 5'd1;
      blow_r   <= '0;
      bhigh_r  <= '0;
      phase_r  <= mbd_pkg::PH_PRE_MATCH;
      mc_r     <= '0;
      fill_r   <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          mbd_pkg::CFG_BLEN:  blen_r  <= cfg_data[4:0];
          mbd_pkg::CFG_BLOW:  blow_r  <= cfg_data;
          mbd_pkg::CFG_BHIGH: bhigh_r <= cfg_data;
          default: begin
            // no register at this index
          end
        endcase
      end
      if (accept) begin
        phase_r <= phase_nxt;
        mc_r    <= mc_nxt;
        fill_r  <= fill_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Delay window: shift in each body byte
  always_ff @(posedge clk) begin
    if (accept && win_load) begin
      for (int j = 0; j < D; j++) begin
        win_r[j] <= w_sh[j];
      end
    end
  end

  // Result queue storage: write one or two entries per transfer
  always_ff @(posedge clk) begin
    if (accept && push_cnt != 2'd0) begin
      oq_r[wr_ptr_r] <= e0;
    end
    if (accept && push_cnt == 2'd2) begin
      oq_r[wr_ptr_r + mbd_pkg::OQ_PTR_W'(1)] <= e1;
    end
  end

endmodule

`default_nettype wire

// ===== dv/mbd_deframer_checker.sv =====
// ----------------------------------------------------------------------------
// mbd_deframer_checker: result checker of the multipart body deframer
// Tracks boundary register writes, parses every accepted input byte with its
// own copy of the parser state, queues the results that byte must produce
// and compares each accepted result transfer against the oldest one queued.
// ----------------------------------------------------------------------------

module mbd_deframer_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  mbd_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  mbd_pkg::res_item_t             out_data,
  output int                             mismatch_count,
  output int                             results_due
);
  import mbd_pkg::*;

  localparam int BND_MAX   = 16;
  localparam int WIN_DEPTH = BND_MAX + 4;

  // boundary registers as last written
  logic [4:0]  blen_reg;
  logic [63:0] blow_reg;
  logic [63:0] bhigh_reg;

  // parser state
  phase_t      phase;
  logic [4:0]  match_cnt;
  logic [7:0]  held_bytes [WIN_DEPTH];
  int          held_count;

  res_item_t   byte_results_q[$];
  res_item_t   parsed_results_q[$];

  function automatic int boundary_len();
    int bl;
    bl = blen_reg;
    if (bl < 1) bl = 1;
    if (bl > BND_MAX) bl = BND_MAX;
    return bl;
  endfunction

  // byte i of the dash-dash-boundary marker
  function automatic logic [7:0] marker_byte(int i);
    if (i < 2) return CH_DASH;
    if (i < 10) return blow_reg[8*(i-2) +: 8];
    if (i < 18) return bhigh_reg[8*(i-10) +: 8];
    return 8'h00;
  endfunction

  // byte i of CR LF followed by the marker
  function automatic logic [7:0] delim_byte(int i);
    if (i == 0) return CH_CR;
    if (i == 1) return CH_LF;
    return marker_byte(i - 2);
  endfunction

  task automatic restart_parse();
    phase      = PH_PRE_MATCH;
    match_cnt  = '0;
    held_count = 0;
    for (int i = 0; i < WIN_DEPTH; i++) held_bytes[i] = '0;
  endtask

  task automatic emit(input kind_t k, input logic [7:0] b, input err_t e);
    res_item_t r;
    r.kind        = k;
    r.out_byte    = b;
    r.error_code  = e;
    r.last_of_run = 1'b0;
    byte_results_q.push_back(r);
  endtask

  task automatic raise_error(input err_t e);
    emit(KIND_ERROR, 8'h00, e);
    phase = PH_ERROR;
  endtask

  // push one part byte into the delay window; once full, release the oldest
  // byte unless the window holds the full part delimiter
  task automatic hold_body_byte(input logic [7:0] b);
    int m;
    int drop;
    bit hit;
    m = boundary_len() + 4;
    if (held_count > m - 1) begin
      drop = held_count - (m - 1);
      for (int i = 0; i < m - 1; i++) held_bytes[i] = held_bytes[i + drop];
      held_count = m - 1;
    end
    held_bytes[held_count] = b;
    held_count++;
    if (held_count < m) return;
    hit = 1'b1;
    for (int i = 0; i < m; i++)
      if (held_bytes[i] != delim_byte(i)) hit = 1'b0;
    if (hit) begin
      emit(KIND_PART_END, 8'h00, ERR_NONE);
      held_count = 0;
      phase      = PH_AFTER_B;
      return;
    end
    emit(KIND_BODY, held_bytes[0], ERR_NONE);
    for (int i = 0; i + 1 < m; i++) held_bytes[i] = held_bytes[i + 1];
    held_count = m - 1;
  endtask

  // advance the parser by one byte and queue the results it produces
  task automatic parse_byte(input logic [7:0] b, input logic eob);
    int len;
    bit prev_cr;
    byte_results_q.delete();
    len = boundary_len() + 2;
    case (phase)
      PH_PRE_MATCH: begin
        if (match_cnt < BND_MAX + 2 && b == marker_byte(match_cnt)) begin
          match_cnt++;
          if (match_cnt >= len) begin
            match_cnt = '0;
            phase     = PH_AFTER_B;
          end
        end else begin
          prev_cr = match_cnt > 0 && match_cnt <= BND_MAX + 2 &&
                    marker_byte(match_cnt - 1) == CH_CR;
          match_cnt = '0;
          if (prev_cr && b == CH_LF) phase = PH_PRE_MATCH;
          else if (b == CH_CR) phase = PH_PRE_SKIP_CR;
          else phase = PH_PRE_SKIP;
        end
      end
      PH_PRE_SKIP, PH_PRE_SKIP_CR: begin
        if (phase == PH_PRE_SKIP_CR && b == CH_LF) begin
          phase     = PH_PRE_MATCH;
          match_cnt = '0;
        end else if (b == CH_CR) begin
          phase = PH_PRE_SKIP_CR;
        end else begin
          phase = PH_PRE_SKIP;
        end
      end
      PH_AFTER_B: begin
        if (!eob) begin
          if (b == CH_DASH) phase = PH_DASH2;
          else if (b == CH_SPACE) phase = PH_SPACES;
          else if (b == CH_CR) phase = PH_B_LF;
          else raise_error(ERR_NO_CRLF);
        end
      end
      PH_DASH2: begin
        if (b == CH_DASH) begin
          emit(KIND_DONE, 8'h00, ERR_NONE);
          phase = PH_DONE;
        end else begin
          raise_error(ERR_NO_CRLF);
        end
      end
      PH_SPACES: begin
        if (b == CH_CR) phase = PH_B_LF;
        else if (b != CH_SPACE) raise_error(ERR_NO_CRLF);
      end
      PH_B_LF: begin
        if (b == CH_LF) phase = PH_LINE_START;
        else raise_error(ERR_NO_CRLF);
      end
      PH_LINE_START: begin
        if (b == CH_CR) begin
          phase = PH_BLANK_LF;
        end else if (b == CH_COLON) begin
          phase = PH_NAME_SP;
        end else begin
          emit(KIND_NAME, b, ERR_NONE);
          phase = PH_NAME;
        end
      end
      PH_BLANK_LF: begin
        if (b == CH_LF) begin
          emit(KIND_HDR_END, 8'h00, ERR_NONE);
          held_count = 0;
          phase      = PH_BODY;
        end else begin
          raise_error(ERR_BLANK);
        end
      end
      PH_NAME: begin
        if (b == CH_COLON) phase = PH_NAME_SP;
        else emit(KIND_NAME, b, ERR_NONE);
      end
      PH_NAME_SP: begin
        if (b == CH_SPACE) phase = PH_VALUE;
        else raise_error(ERR_NO_SPACE);
      end
      PH_VALUE: begin
        if (b == CH_CR) phase = PH_VALUE_LF;
        else emit(KIND_VALUE, b, ERR_NONE);
      end
      PH_VALUE_LF: begin
        if (b == CH_LF) begin
          emit(KIND_LINE_END, 8'h00, ERR_NONE);
          phase = PH_LINE_START;
        end else begin
          raise_error(ERR_NO_LF);
        end
      end
      PH_BODY: hold_body_byte(b);
      default: ;
    endcase

    // end of body: flag an unfinished body, drop held bytes, start over
    if (eob) begin
      if (phase != PH_DONE && phase != PH_ERROR) emit(KIND_ERROR, 8'h00, ERR_PREMATURE);
      restart_parse();
    end
    if (byte_results_q.size() > 0)
      byte_results_q[byte_results_q.size() - 1].last_of_run = 1'b1;
    foreach (byte_results_q[i]) parsed_results_q.push_back(byte_results_q[i]);
  endtask

  task automatic check_result(input res_item_t got);
    res_item_t want;
    if (parsed_results_q.size() == 0) begin
      $error("unexpected result: kind %0d out_byte %0h", got.kind, got.out_byte);
      mismatch_count++;
      return;
    end
    want = parsed_results_q.pop_front();
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, actual %0d", want.kind, got.kind);
      mismatch_count++;
    end
    if (got.out_byte !== want.out_byte) begin
      $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
      mismatch_count++;
    end
    if (got.error_code !== want.error_code) begin
      $error("error_code: expected %0d, actual %0d", want.error_code, got.error_code);
      mismatch_count++;
    end
    if (got.last_of_run !== want.last_of_run) begin
      $error("last_of_run: expected %0b, actual %0b", want.last_of_run, got.last_of_run);
      mismatch_count++;
    end
  endtask

  // compare results first: a result leaving now never stems from the byte
  // entering at the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      blen_reg       = 5'd1;
      blow_reg       = '0;
      bhigh_reg      = '0;
      mismatch_count = 0;
      parsed_results_q.delete();
      restart_parse();
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_BLEN:  blen_reg  = cfg_data[4:0];
          CFG_BLOW:  blow_reg  = cfg_data;
          CFG_BHIGH: bhigh_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) parse_byte(in_data.in_byte, in_data.end_of_body);
    end
    results_due <= parsed_results_q.size();
  end

endmodule

// ===== dv/multipart_body_deframer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// multipart_body_deframer_unit_tb: stimulus and verdict for the deframer
// Feeds short directed bodies, then random multipart bodies built from
// preamble, boundary lines, headers and part data, with noise, corruption,
// truncation and boundary changes between and inside bodies. Both channels
// idle at random. The checker beside the block predicts every result.
// ----------------------------------------------------------------------------

module multipart_body_deframer_unit_tb;
  import mbd_pkg::*;

  localparam int BND_MAX      = 16;
  localparam int RANDOM_ITEMS = 480;
  localparam int CYCLE_LIMIT  = 200000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  res_item_t             out_data;

  int                    mismatch_count;
  int                    results_due;
  int                    cycle_count = 0;
  int                    item_count  = 0;
  logic                  calm        = 1'b0;

  // boundary in use and the body being assembled
  logic [127:0]          bnd_bits;
  int                    bnd_len;
  logic [7:0]            frame_q[$];

  multipart_body_deframer_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  mbd_deframer_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  always #5 clk = ~clk;

  // stall the result channel now and then, never while calm
  always @(posedge clk) begin
    if (calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 6);
  end

  // hard stop
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** multipart_body_deframer_unit: FAILED **");
      $finish;
    end
  end

  // offer one byte and return right after the edge that takes it
  task automatic send_byte(input logic [7:0] b, input logic eob);
    while (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, end_of_body: eob};
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  // drain all results, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_length(input logic [4:0] code);
    logic [CFG_DATA_W-1:0] data;
    data      = {$urandom, $urandom};
    data[4:0] = code;
    bnd_len   = (code == 0) ? 1 : ((code > BND_MAX) ? BND_MAX : code);
    write_reg(CFG_BLEN, data);
  endtask

  task automatic load_boundary(input logic [4:0] code, input logic [127:0] bits);
    bnd_bits = bits;
    write_length(code);
    write_reg(CFG_BLOW, bits[63:0]);
    write_reg(CFG_BHIGH, bits[127:64]);
  endtask

  function automatic logic [4:0] pick_length_code();
    case ($urandom_range(9))
      0: return 5'd0;
      1: return 5'd31;
      2: return 5'd16;
      3: return 5'd1;
      default: return 5'($urandom_range(2, 5));
    endcase
  endfunction

  function automatic logic [7:0] letter();
    return 8'h61 + 8'($urandom_range(3));
  endfunction

  function automatic logic [7:0] boundary_char();
    case ($urandom_range(11))
      0: return CH_DASH;
      1: return CH_SPACE;
      2: return CH_CR;
      3: return CH_LF;
      default: return letter();
    endcase
  endfunction

  function automatic logic [7:0] text_char();
    if ($urandom_range(7) == 0) return CH_SPACE;
    return 8'h61 + 8'($urandom_range(25));
  endfunction

  // part data: mostly bytes that come close to the delimiter
  function automatic logic [7:0] part_char();
    case ($urandom_range(7))
      0: return CH_CR;
      1: return CH_LF;
      2: return CH_DASH;
      3, 4: return 8'($urandom_range(255));
      5: return bnd_bits[8*$urandom_range(bnd_len - 1) +: 8];
      default: return letter();
    endcase
  endfunction

  // random boundary, sometimes with a CR LF pair inside
  task automatic pick_boundary();
    logic [4:0]   code;
    logic [127:0] bits;
    int           eff;
    int           pos;
    code = pick_length_code();
    eff  = (code == 0) ? 1 : ((code > BND_MAX) ? BND_MAX : code);
    bits = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < eff; i++) bits[8*i +: 8] = boundary_char();
    if (eff >= 3 && $urandom_range(4) == 0) begin
      pos = $urandom_range(eff - 2);
      bits[8*pos +: 8]     = CH_CR;
      bits[8*pos + 8 +: 8] = CH_LF;
    end
    load_boundary(code, bits);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endtask

  task automatic push_crlf();
    frame_q.push_back(CH_CR);
    frame_q.push_back(CH_LF);
  endtask

  task automatic push_marker(input int n);
    frame_q.push_back(CH_DASH);
    frame_q.push_back(CH_DASH);
    for (int i = 0; i < n; i++) frame_q.push_back(bnd_bits[8*i +: 8]);
  endtask

  // assemble one random body; split_at marks a byte after which the
  // boundary length gets rewritten, -1 for none
  task automatic build_body(output int split_at);
    int parts;
    int pos;
    split_at = -1;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(3, 20)) frame_q.push_back(8'($urandom_range(255)));
      return;
    end
    // preamble, with lines that start like the marker and break off
    repeat ($urandom_range(2)) begin
      if ($urandom_range(1)) begin
        push_marker($urandom_range(bnd_len - 1));
        frame_q.push_back(8'h5a);
      end
      repeat ($urandom_range(6)) frame_q.push_back(text_char());
      push_crlf();
    end
    parts = $urandom_range(1, 3);
    repeat (parts) begin
      push_marker(bnd_len);
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) frame_q.push_back(CH_SPACE);
      push_crlf();
      repeat ($urandom_range(2)) begin
        if ($urandom_range(5) != 0) repeat ($urandom_range(1, 4)) frame_q.push_back(letter());
        frame_q.push_back(CH_COLON);
        frame_q.push_back(CH_SPACE);
        repeat ($urandom_range(5)) frame_q.push_back(text_char());
        push_crlf();
      end
      push_crlf();
      pos = frame_q.size();
      repeat ($urandom_range(12)) frame_q.push_back(part_char());
      if (split_at < 0 && frame_q.size() > pos && $urandom_range(5) == 0)
        split_at = $urandom_range(pos, frame_q.size() - 1);
      push_crlf();
    end
    push_marker(bnd_len);
    frame_q.push_back(CH_DASH);
    frame_q.push_back(CH_DASH);
    repeat ($urandom_range(2)) frame_q.push_back(text_char());
    // break some bodies: overwrite one byte or cut the body short
    if ($urandom_range(4) == 0) begin
      pos = $urandom_range(frame_q.size() - 1);
      if ($urandom_range(1)) frame_q[pos] = 8'($urandom_range(255));
      else while (frame_q.size() > pos + 1) void'(frame_q.pop_back());
    end
  endtask

  // send the assembled body, end_of_body on its last byte
  task automatic send_frame(input int split_at);
    for (int i = 0; i < frame_q.size(); i++) begin
      send_byte(frame_q[i], i == frame_q.size() - 1);
      item_count++;
      if (i == split_at && i < frame_q.size() - 1) begin
        wait_idle();
        write_length(pick_length_code());
      end
    end
    frame_q.delete();
  endtask

  initial begin : stimulus
    int split_at;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed bodies with the one-byte boundary "x"
    load_boundary(5'd1, {$urandom, $urandom, $urandom, 24'($urandom), 8'h78});
    push_str("--x--");
    send_frame(-1);
    // end on the first byte after the boundary
    push_str("--x-");
    send_frame(-1);
    // dash then non-dash after the boundary
    push_str("--x-");
    frame_q.push_back(8'h00);
    send_frame(-1);
    // end inside the preamble
    frame_q.push_back(8'hff);
    send_frame(-1);
    // empty header name, one part with data
    push_str("--x");
    push_crlf();
    push_str(": v");
    push_crlf();
    push_crlf();
    push_str("b");
    push_crlf();
    push_str("--x--");
    send_frame(-1);

    // random bodies
    item_count = 0;
    while (item_count < RANDOM_ITEMS) begin
      calm <= (item_count >= 160 && item_count < 300);
      if ($urandom_range(2) == 0) begin
        wait_idle();
        pick_boundary();
      end
      build_body(split_at);
      send_frame(split_at);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0) begin
      $display("** multipart_body_deframer_unit: PASSED **");
    end else begin
      $display("** multipart_body_deframer_unit: FAILED **");
    end
    $finish;
  end

endmodule
